### rtl/wphd_pkg.sv
// Package for the waypoint heading and distance block: widths, angle constants,
// the CORDIC arctangent step table and the record handed along the cell chain.
// No dependencies.
package wphd_pkg;

  // Number of CORDIC cells in the chain (8 to 24, limited by the table).
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;

  // Datapath widths.
  localparam int CW        = 34;  // CORDIC x/y word, coordinates scaled by 2^6
  localparam int ZW        = 25;  // angle accumulator, degrees times 2^16
  localparam int TW        = 18;  // raw turn angle before wrapping
  localparam int HW        = 16;  // heading
  localparam int GUARD     = 6;
  localparam int ANG_SHIFT = 10;

  // Gain correction, about 0.6072529350 in unsigned Q0.32.
  localparam logic [31:0] GAIN = 32'd2608131496;

  // Angles in degrees times 64.
  localparam int DEG90  = 5760;
  localparam int DEG180 = 11520;
  localparam int DEG270 = 17280;
  localparam int DEG360 = 23040;

  localparam logic signed [TW-1:0] TURN_0   = '0;
  localparam logic signed [TW-1:0] TURN_90  = TW'(DEG90);
  localparam logic signed [TW-1:0] TURN_180 = TW'(DEG180);
  localparam logic signed [TW-1:0] TURN_270 = TW'(DEG270);
  localparam logic signed [TW-1:0] TURN_360 = TW'(DEG360);
  localparam logic signed [TW-1:0] TURN_540 = TW'(DEG180 + DEG360);
  localparam logic signed [TW-1:0] TURN_720 = TW'(2 * DEG360);

  // Record carried from cell to cell.
  typedef struct packed {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic signed [ZW-1:0] z;
    logic signed [HW-1:0] heading;
    logic                 empty;
    logic                 dy_pos;
    logic                 dy_neg;
    logic                 dx_zero;
    logic                 dx_pos;
  } cell_data_t;

  // Rounded atan(2^-i) in degrees times 2^16.
  function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 25'sd2949120;
      5'd1:    r = 25'sd1740967;
      5'd2:    r = 25'sd919879;
      5'd3:    r = 25'sd466945;
      5'd4:    r = 25'sd234379;
      5'd5:    r = 25'sd117304;
      5'd6:    r = 25'sd58666;
      5'd7:    r = 25'sd29335;
      5'd8:    r = 25'sd14668;
      5'd9:    r = 25'sd7334;
      5'd10:   r = 25'sd3667;
      5'd11:   r = 25'sd1833;
      5'd12:   r = 25'sd917;
      5'd13:   r = 25'sd458;
      5'd14:   r = 25'sd229;
      5'd15:   r = 25'sd115;
      5'd16:   r = 25'sd57;
      5'd17:   r = 25'sd29;
      5'd18:   r = 25'sd14;
      5'd19:   r = 25'sd7;
      5'd20:   r = 25'sd4;
      5'd21:   r = 25'sd2;
      5'd22:   r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/waypoint_heading_distance.sv
// Top level of the waypoint heading and distance block: entry stage, a chain of
// CORDIC cells and the result stages. Depends on wphd_pkg, wphd_prep, wphd_cell
// and wphd_post.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   pos_x, pos_y, dest_x, dest_y, heading, dest_empty
//   output   out_valid / out_ready turn_angle, travel_distance, obsolete
//
// One item enters per cycle while the output is not stalled; out_valid rises once the
// item has passed the entry stage, the chain of cells and the result stages.
// Every stage has its own valid bit, so bubbles close up and a stalled output
// only holds back stages that are full. Reset clears the valid bits only.
module waypoint_heading_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        pos_x,
  input  logic [23:0]        pos_y,
  input  logic [23:0]        dest_x,
  input  logic [23:0]        dest_y,
  input  logic [15:0]        heading,
  input  logic               dest_empty,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] turn_angle,
  output logic [24:0]        travel_distance,
  output logic               obsolete
);
  import wphd_pkg::*;

  cell_data_t chain_data  [0:CORDIC_STEPS];
  logic       chain_valid [0:CORDIC_STEPS];
  logic       chain_ready [0:CORDIC_STEPS];

  // Entry stage.
  wphd_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .heading    (heading),
    .dest_empty (dest_empty),
    .dn_valid   (chain_valid[0]),
    .dn_ready   (chain_ready[0]),
    .dn_data    (chain_data[0])
  );

  // Chain of micro-rotation cells, cell k shifting by k.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    wphd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step_idx (STEP_W'(k)),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_data  (chain_data[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_data  (chain_data[k+1])
    );
  end

  // Gain correction, bearing and output register.
  wphd_post u_post (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (chain_valid[CORDIC_STEPS]),
    .up_ready        (chain_ready[CORDIC_STEPS]),
    .up_data         (chain_data[CORDIC_STEPS]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .turn_angle      (turn_angle),
    .travel_distance (travel_distance),
    .obsolete        (obsolete)
  );

endmodule

### rtl/wphd_prep.sv
// Entry stage: forms the difference vector, folds it into the right half plane
// and registers the first record of the cell chain. Depends on wphd_pkg.
module wphd_prep (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [23:0]             pos_x,
  input  logic [23:0]             pos_y,
  input  logic [23:0]             dest_x,
  input  logic [23:0]             dest_y,
  input  logic [15:0]             heading,
  input  logic                    dest_empty,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output wphd_pkg::cell_data_t    dn_data
);
  import wphd_pkg::*;

  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [25:0] ndx;
  logic signed [25:0] ndy;
  logic signed [25:0] u0;
  logic signed [25:0] v0;
  cell_data_t         data_next;
  logic               valid;

  // Difference vector and quadrant flags.
  always_comb begin
    dx  = {dest_x[23], dest_x} - {pos_x[23], pos_x};
    dy  = {dest_y[23], dest_y} - {pos_y[23], pos_y};
    ndx = -{dx[24], dx};
    ndy = -{dy[24], dy};

    data_next.dy_pos  = !dy[24] && (dy != '0);
    data_next.dy_neg  = dy[24];
    data_next.dx_zero = (dx == '0);
    data_next.dx_pos  = !dx[24] && (dx != '0);
    data_next.empty   = dest_empty;
    data_next.heading = heading;
    data_next.z       = '0;

    // Fold the vector so that the CORDIC x input is never negative.
    if (data_next.dy_pos) begin
      u0 = {dy[24], dy};
      v0 = {dx[24], dx};
    end else if (data_next.dy_neg) begin
      u0 = ndy;
      v0 = ndx;
    end else begin
      u0 = dx[24] ? ndx : {dx[24], dx};
      v0 = '0;
    end

    data_next.u = {{(CW - 26 - GUARD){u0[25]}}, u0, {GUARD{1'b0}}};
    data_next.v = {{(CW - 26 - GUARD){v0[25]}}, v0, {GUARD{1'b0}}};
  end

  // Stage register with its own transfer control.
  assign in_ready = !valid || dn_ready;
  assign dn_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

### rtl/wphd_cell.sv
// One CORDIC vectoring cell: a single micro-rotation on the record it takes in,
// registered for the next cell. Depends on wphd_pkg.
module wphd_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [wphd_pkg::STEP_W-1:0] step_idx,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  wphd_pkg::cell_data_t    up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output wphd_pkg::cell_data_t    dn_data
);
  import wphd_pkg::*;

  logic signed [CW-1:0] u_in;
  logic signed [CW-1:0] v_in;
  logic signed [CW-1:0] us;
  logic signed [CW-1:0] vs;
  logic signed [ZW-1:0] step_ang;
  cell_data_t           data_next;
  logic                 valid;

  // Rotate towards the x axis by the angle of this cell.
  always_comb begin
    u_in      = up_data.u;
    v_in      = up_data.v;
    us        = u_in >>> step_idx;
    vs        = v_in >>> step_idx;
    step_ang  = atan_step(step_idx);
    data_next = up_data;
    if (!v_in[CW-1]) begin
      data_next.u = u_in + vs;
      data_next.v = v_in - us;
      data_next.z = up_data.z + step_ang;
    end else begin
      data_next.u = u_in - vs;
      data_next.v = v_in + us;
      data_next.z = up_data.z - step_ang;
    end
  end

  // Cell register; it takes a new record whenever it is empty or passing one on.
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

### rtl/wphd_post.sv
// Result stages: gain correction of the magnitude as two partial products,
// bearing selection, turn wrapping and the output register. Depends on wphd_pkg.
module wphd_post (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  wphd_pkg::cell_data_t    up_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [14:0]      turn_angle,
  output logic [24:0]             travel_distance,
  output logic                    obsolete
);
  import wphd_pkg::*;

  // Stage 1 registers.
  logic                 v1;
  logic [47:0]          prod_lo;
  logic [48:0]          prod_hi;
  logic signed [TW-1:0] turn_raw;
  logic                 empty1;
  // Stage 2 registers.
  logic                 v2;
  logic [65:0]          mag_sum;
  logic signed [TW-1:0] turn_wrap;
  logic                 empty2;
  // Output register.
  logic                 v3;

  logic                 r1;
  logic                 r2;
  logic                 r3;

  logic [CW-2:0]        u_pos;
  logic signed [ZW:0]   z_round;
  logic signed [ZW:0]   z_shift;
  logic signed [TW-1:0] bearing;
  logic signed [TW-1:0] turn_calc;
  logic signed [TW-1:0] wrap_calc;
  logic [27:0]          dist_full;
  logic [24:0]          dist_sat;

  // Ready chain through the three stages.
  assign r3        = !v3 || out_ready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign up_ready  = r1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= up_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: magnitude partial products and the raw turn angle.
  always_comb begin
    u_pos   = up_data.u[CW-1] ? '0 : up_data.u[CW-2:0];
    z_round = {up_data.z[ZW-1], up_data.z}
              + {{(ZW - ANG_SHIFT + 1){1'b0}}, 1'b1, {(ANG_SHIFT - 1){1'b0}}};
    z_shift = z_round >>> ANG_SHIFT;
    if (up_data.dy_pos) begin
      bearing = TW'(z_shift);
    end else if (up_data.dy_neg) begin
      bearing = TW'(z_shift) - TURN_180;
    end else if (up_data.dx_zero) begin
      bearing = TURN_0;
    end else if (up_data.dx_pos) begin
      bearing = TURN_90;
    end else begin
      bearing = TURN_270;
    end
    turn_calc = bearing - TW'(up_data.heading);
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      prod_lo  <= 48'(u_pos[15:0]) * 48'(GAIN);
      prod_hi  <= 49'(u_pos[CW-2:16]) * 49'(GAIN);
      turn_raw <= turn_calc;
      empty1   <= up_data.empty;
    end
  end

  // Stage 2: sum with rounding, and wrap the turn into the closed range of +-180 degrees.
  always_comb begin
    if (turn_raw > TURN_540) begin
      wrap_calc = turn_raw - TURN_720;
    end else if (turn_raw > TURN_180) begin
      wrap_calc = turn_raw - TURN_360;
    end else if (turn_raw < -TURN_540) begin
      wrap_calc = turn_raw + TURN_720;
    end else if (turn_raw < -TURN_180) begin
      wrap_calc = turn_raw + TURN_360;
    end else begin
      wrap_calc = turn_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      mag_sum   <= 66'(prod_lo) + (66'(prod_hi) << 16) + (66'(1) << (31 + GUARD));
      turn_wrap <= wrap_calc;
      empty2    <= empty1;
    end
  end

  // Stage 3: scale down, saturate and blank the result when there is no target.
  always_comb begin
    dist_full = mag_sum[65:38];
    dist_sat  = (|dist_full[27:25]) ? '1 : dist_full[24:0];
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      turn_angle      <= empty2 ? '0 : 15'(turn_wrap);
      travel_distance <= empty2 ? '0 : dist_sat;
      obsolete        <= empty2;
    end
  end

endmodule

### bench/tb_top.sv
// Self-checking testbench for waypoint_heading_distance: directed and random waypoints,
// a bit-exact CORDIC course predictor, and random idling on both channels.
// Depends on wphd_pkg and the waypoint_heading_distance RTL.
module tb_top;
  import wphd_pkg::*;

  localparam int LATENCY     = CORDIC_STEPS + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WPS  = 650;

  typedef struct {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] tx;
    logic [23:0] ty;
    logic [15:0] hdg;
    logic        empty;
  } waypoint_t;

  typedef struct {
    logic signed [14:0] turn;
    logic [24:0]        distance;
    logic               obs;
  } course_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [23:0] pos_x      = '0;
  logic [23:0] pos_y      = '0;
  logic [23:0] dest_x     = '0;
  logic [23:0] dest_y     = '0;
  logic [15:0] heading    = '0;
  logic        dest_empty = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] turn_angle;
  logic [24:0]        travel_distance;
  logic               obsolete;

  waypoint_t waypoints_pending[$];
  course_t   courses_expected[$];
  waypoint_t cur_wp;

  int cycle_count     = 0;
  int mismatches      = 0;
  int waypoints_sent  = 0;
  int courses_checked = 0;

  // Arctangent of 2^-i in degrees times 2^16.
  longint atan_deg16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  waypoint_heading_distance u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .dest_x          (dest_x),
    .dest_y          (dest_y),
    .heading         (heading),
    .dest_empty      (dest_empty),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .turn_angle      (turn_angle),
    .travel_distance (travel_distance),
    .obsolete        (obsolete)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Bearing and distance by CORDIC vectoring, then the turn wrapped into +-180 degrees.
  function automatic course_t predict_course(input waypoint_t w);
    course_t    r;
    longint     dx, dy, u, v, z, us, vs, brg, turn;
    logic [95:0] prod;
    int         i;
    r.turn     = '0;
    r.distance = '0;
    r.obs      = 1'b1;
    if (w.empty) begin
      return r;
    end
    dx = longint'($signed(w.tx)) - longint'($signed(w.px));
    dy = longint'($signed(w.ty)) - longint'($signed(w.py));
    // Fold the vector into the right half-plane measured from +y.
    if (dy > 0) begin
      u = dy;
      v = dx;
    end else if (dy < 0) begin
      u = -dy;
      v = -dx;
    end else begin
      u = (dx < 0) ? -dx : dx;
      v = 0;
    end
    u = u * (longint'(1) << GUARD);
    v = v * (longint'(1) << GUARD);
    z = 0;
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      us = u >>> i;
      vs = v >>> i;
      if (v >= 0) begin
        u = u + vs;
        v = v - us;
        z = z + atan_deg16[i];
      end else begin
        u = u - vs;
        v = v + us;
        z = z - atan_deg16[i];
      end
    end
    if (u < 0) begin
      u = 0;
    end
    // Gain correction, rounded half up, saturated to the output width.
    prod = 96'(u) * 96'(GAIN) + (96'(1) << (31 + GUARD));
    prod = prod >> (32 + GUARD);
    if (prod > 96'(33554431)) begin
      prod = 96'(33554431);
    end
    if (dy > 0) begin
      brg = (z + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    end else if (dy < 0) begin
      brg = ((z + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT) - DEG180;
    end else if (dx == 0) begin
      brg = 0;
    end else if (dx > 0) begin
      brg = DEG90;
    end else begin
      brg = DEG270;
    end
    turn = brg - longint'($signed(w.hdg));
    while (turn > DEG180) begin
      turn = turn - DEG360;
    end
    while (turn < -DEG180) begin
      turn = turn + DEG360;
    end
    r.turn     = turn[14:0];
    r.distance = prod[24:0];
    r.obs      = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic add_waypoint(input logic [23:0] px, input logic [23:0] py,
                              input logic [23:0] tx, input logic [23:0] ty,
                              input logic [15:0] hdg, input logic empty);
    waypoint_t w;
    w.px    = px;
    w.py    = py;
    w.tx    = tx;
    w.ty    = ty;
    w.hdg   = hdg;
    w.empty = empty;
    waypoints_pending.push_back(w);
  endtask

  // Input driver: holds each waypoint until its transfer, with random gaps.
  always @(posedge clk) begin : wp_driver
    logic calm;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        courses_expected.push_back(predict_course(cur_wp));
        waypoints_sent++;
      end
      calm = (waypoints_sent >= 300) && (waypoints_sent < 420);
      if (!in_valid || in_ready) begin
        if (waypoints_pending.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          cur_wp = waypoints_pending.pop_front();
          pos_x      <= cur_wp.px;
          pos_y      <= cur_wp.py;
          dest_x     <= cur_wp.tx;
          dest_y     <= cur_wp.ty;
          heading    <= cur_wp.hdg;
          dest_empty <= cur_wp.empty;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer out against the oldest expected course.
  always @(posedge clk) begin : course_monitor
    course_t want;
    logic    calm;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (courses_expected.size() == 0) begin
          report_mismatch("result with nothing expected, turn_angle", turn_angle, 0);
        end else begin
          want = courses_expected.pop_front();
          if (turn_angle !== want.turn) begin
            report_mismatch("turn_angle", longint'(turn_angle), longint'(want.turn));
          end
          if (travel_distance !== want.distance) begin
            report_mismatch("travel_distance", travel_distance, want.distance);
          end
          if (obsolete !== want.obs) begin
            report_mismatch("obsolete", obsolete, want.obs);
          end
        end
        courses_checked++;
      end
      calm = (courses_checked >= 300) && (courses_checked < 420);
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int          kind;
    logic [23:0] px, py, tx, ty;
    logic [15:0] hdg;
    logic        empty;

    // Directed: no target, zero vector, axis cases, extremes and exact half turns.
    add_waypoint(24'h123456, 24'hABCDEF, 24'h000000, 24'h7FFFFF, 16'h1234, 1'b1);
    add_waypoint(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'h8000, 1'b1);
    add_waypoint(24'h001000, 24'h001000, 24'h001000, 24'h001000, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000100, 24'h000000, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFF00, 24'h000000, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000000, 24'h000100, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000000, 24'hFFFF00, 16'h0000, 1'b0);
    add_waypoint(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 1'b0);
    add_waypoint(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'h0000, 1'b0);
    add_waypoint(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'h0000, 1'b0);
    add_waypoint(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000001, 24'h000001, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFFFF, 24'h000001, 16'h0000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF, 16'h0000, 1'b0);
    // Bearing 0 against a heading of +-180 gives the exact half turn, kept as is.
    add_waypoint(24'h000000, 24'h000000, 24'h000000, 24'h000200, 16'(DEG180), 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000000, 24'h000200, -16'(DEG180), 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFE00, 24'h000000, -16'(DEG180), 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFE00, 24'h000000, 16'd23039, 1'b0);
    // Headings outside the nominal range, some of which need more than one wrap.
    add_waypoint(24'h000000, 24'h000000, 24'h000300, 24'hFFFD00, 16'h7FFF, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFD00, 24'h000300, 16'h8000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'hFFFE00, 24'h000000, 16'h8000, 1'b0);
    add_waypoint(24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'h7FFF, 1'b0);

    // Random: mostly real targets, with the axis and degenerate cases mixed in.
    repeat (RANDOM_WPS) begin
      kind  = $urandom_range(99);
      px    = 24'($urandom);
      py    = 24'($urandom);
      tx    = 24'($urandom);
      ty    = 24'($urandom);
      empty = (kind < 8);
      if ($urandom_range(9) == 0) begin
        hdg = 16'($urandom);
      end else begin
        hdg = 16'($urandom_range(34559) - 11520);
      end
      if (kind >= 8 && kind < 14) begin
        ty = py;
      end else if (kind >= 14 && kind < 19) begin
        tx = px;
      end else if (kind >= 19 && kind < 22) begin
        tx = px;
        ty = py;
      end else if (kind >= 22 && kind < 50) begin
        tx = px + 24'($urandom_range(512)) - 24'd256;
        ty = py + 24'($urandom_range(512)) - 24'd256;
      end
      add_waypoint(px, py, tx, ty, hdg, empty);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (waypoints_pending.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (courses_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (courses_expected.size() != 0) begin
      report_mismatch("results never received", 0, courses_expected.size());
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
